// File: rtl/joystick_radial_dead_zone_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radial dead-zone core
// Concurrent checks that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_RADIAL_DEAD_ZONE_CORE_ASSERT_SVH
`define JOYSTICK_RADIAL_DEAD_ZONE_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication check
`define JRDZ_ASSERT_IMP(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("jrdz same-cycle check failed");
// Next-cycle implication check
`define JRDZ_ASSERT_NXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("jrdz next-cycle check failed");
`else
`define JRDZ_ASSERT_IMP(lbl, ck, rn, pre, post)
`define JRDZ_ASSERT_NXT(lbl, ck, rn, pre, post)
`endif

`endif

// File: rtl/jrdz_pkg.sv
// ----------------------------------------------------------------------------
// jrdz_pkg
// Shared constants, mode codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package jrdz_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Angle path: degrees * 65536 inside, degrees * 64 at the port
  localparam int ANG_W     = 15;
  localparam int ZW        = 27;
  localparam int ANG_SHIFT = 10;
  localparam logic signed [ZW-1:0] ANG_ROUND = 27'sd512;
  localparam logic signed [ZW-1:0] ANG_LIMIT = 27'sd11520;
  localparam logic signed [ZW-1:0] HALF_TURN = 27'sd11796480;

  // Corrected-length selection
  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_DIV  = 2'd2;

  // Configuration register indexes
  localparam logic REG_INNER = 1'b0;
  localparam logic REG_OUTER = 1'b1;

  // atan(2^-i) in degrees * 65536
  function automatic logic signed [ZW-1:0] atan_deg16(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:    a = 27'sd2949120;
      5'd1:    a = 27'sd1740967;
      5'd2:    a = 27'sd919879;
      5'd3:    a = 27'sd466945;
      5'd4:    a = 27'sd234379;
      5'd5:    a = 27'sd117304;
      5'd6:    a = 27'sd58666;
      5'd7:    a = 27'sd29335;
      5'd8:    a = 27'sd14668;
      5'd9:    a = 27'sd7334;
      5'd10:   a = 27'sd3667;
      5'd11:   a = 27'sd1833;
      5'd12:   a = 27'sd917;
      5'd13:   a = 27'sd458;
      5'd14:   a = 27'sd229;
      5'd15:   a = 27'sd115;
      5'd16:   a = 27'sd57;
      5'd17:   a = 27'sd29;
      5'd18:   a = 27'sd14;
      5'd19:   a = 27'sd7;
      5'd20:   a = 27'sd4;
      5'd21:   a = 27'sd2;
      5'd22:   a = 27'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/joystick_radial_dead_zone_core.sv
// ----------------------------------------------------------------------------
// joystick_radial_dead_zone_core
// Radial dead-zone correction of one stick sample per cycle while in_stall is low.
// ----------------------------------------------------------------------------
// One sample enters per clock while in_stall is low. The path is a pipeline:
// squares, a bit-pair square root (one root bit per stage), a restoring
// divider for the corrected length (one quotient bit per stage), two rescale
// dividers by the raw length, saturation, and a CORDIC vectoring chain (one
// rotation per stage). All stages advance together; while a finished
// transaction waits at a stalled output, the whole pipeline holds and
// in_stall is high. Dead-zone registers may be written only when the
// pipeline is empty.
// ----------------------------------------------------------------------------
`include "joystick_radial_dead_zone_core_assert.svh"

module joystick_radial_dead_zone_core #(
  parameter int SAMPLE_BITS  = jrdz_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = jrdz_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [SAMPLE_BITS-1:0]        cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_raw_x,
  input  logic signed [SAMPLE_BITS-1:0] in_raw_y,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_corrected_x,
  output logic signed [SAMPLE_BITS-1:0] out_corrected_y,
  output logic [SAMPLE_BITS-1:0]        out_magnitude,
  output logic signed [jrdz_pkg::ANG_W-1:0] out_orientation_deg,
  output logic signed [SAMPLE_BITS-1:0] out_raw_echo_x,
  output logic signed [SAMPLE_BITS-1:0] out_raw_echo_y
);

  localparam int W  = SAMPLE_BITS;
  localparam int N  = CORDIC_STEPS;
  localparam int CW = W + 11;
  localparam int ZW = jrdz_pkg::ZW;
  localparam int AW = jrdz_pkg::ANG_W;
  localparam logic [W-1:0] FULL_U  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

  logic pipe_en;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [W-1:0] inner_r, outer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '0;
      outer_r <= FULL_U;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        jrdz_pkg::REG_INNER: inner_r <= cfg_wdata;
        jrdz_pkg::REG_OUTER: outer_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register and pipeline enable
  // --------------------------------------------------------------------------
  logic                 out_valid_r;
  logic signed [W-1:0]  out_corrected_x_r, out_corrected_y_r;
  logic [W-1:0]         out_magnitude_r;
  logic signed [AW-1:0] out_orientation_deg_r;
  logic signed [W-1:0]  out_raw_echo_x_r, out_raw_echo_y_r;

  // advance everything unless a finished transaction is held
  assign pipe_en  = !out_valid_r || !out_stall;
  assign in_stall = !pipe_en;

  // --------------------------------------------------------------------------
  // Stage A: capture the sample
  // --------------------------------------------------------------------------
  logic                a_vld_r;
  logic signed [W-1:0] a_x_r, a_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (pipe_en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_x_r <= in_raw_x;
      a_y_r <= in_raw_y;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: squares
  // --------------------------------------------------------------------------
  logic                  b_vld_r;
  logic signed [W-1:0]   b_x_r, b_y_r;
  logic [2*W-1:0]        b_xx_r, b_yy_r;
  logic signed [2*W-1:0] b_xx_nxt, b_yy_nxt;

  assign b_xx_nxt = a_x_r * a_x_r;
  assign b_yy_nxt = a_y_r * a_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (pipe_en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      b_x_r  <= a_x_r;
      b_y_r  <= a_y_r;
      b_xx_r <= b_xx_nxt;
      b_yy_r <= b_yy_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: entry register, then one root bit per stage
  // --------------------------------------------------------------------------
  logic                sq_vld_r  [W+1];
  logic signed [W-1:0] sq_x_r    [W+1];
  logic signed [W-1:0] sq_y_r    [W+1];
  logic [2*W-1:0]      sq_v_r    [W+1];
  logic [W:0]          sq_rem_r  [W+1];
  logic [W-1:0]        sq_root_r [W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (pipe_en) begin
      sq_vld_r[0] <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_x_r[0]    <= b_x_r;
      sq_y_r[0]    <= b_y_r;
      sq_v_r[0]    <= b_xx_r + b_yy_r;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_sqrt
    localparam int I = W - 1 - s;
    logic [W+2:0] sh, trial, diff;
    logic         ge;

    // bring down the next bit pair and try the next root bit
    assign sh    = {sq_rem_r[s], sq_v_r[s][2*I+1 -: 2]};
    assign trial = {1'b0, sq_root_r[s], 2'b01};
    assign ge    = sh >= trial;
    assign diff  = sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[s+1] <= 1'b0;
      end else if (pipe_en) begin
        sq_vld_r[s+1] <= sq_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sq_x_r[s+1]    <= sq_x_r[s];
        sq_y_r[s+1]    <= sq_y_r[s];
        sq_v_r[s+1]    <= sq_v_r[s];
        sq_rem_r[s+1]  <= ge ? diff[W:0] : sh[W:0];
        sq_root_r[s+1] <= {sq_root_r[s][W-2:0], ge};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Corrected length: classify, then divide one quotient bit per stage
  // --------------------------------------------------------------------------
  logic                td_vld_r  [W+1];
  logic signed [W-1:0] td_x_r    [W+1];
  logic signed [W-1:0] td_y_r    [W+1];
  logic [W-1:0]        td_len_r  [W+1];
  logic [1:0]          td_mode_r [W+1];
  logic [W-1:0]        td_span_r [W+1];
  logic [W-1:0]        td_lo_r   [W+1];
  logic [W-1:0]        td_rem_r  [W+1];
  logic [W-1:0]        td_q_r    [W+1];

  logic [W-1:0]   td_len, td_span, td_d;
  logic [1:0]     td_mode_nxt;
  logic [2*W-1:0] td_num;

  assign td_len  = sq_root_r[W];
  assign td_span = outer_r - inner_r;
  assign td_d    = td_len - inner_r;
  assign td_num  = {1'b0, td_d, {(W-1){1'b0}}} + {{(W+1){1'b0}}, td_span[W-1:1]};

  always_comb begin
    if (td_len <= inner_r) begin
      td_mode_nxt = jrdz_pkg::MODE_ZERO;
    end else if (outer_r <= inner_r || td_len >= outer_r) begin
      td_mode_nxt = jrdz_pkg::MODE_FULL;
    end else begin
      td_mode_nxt = jrdz_pkg::MODE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      td_vld_r[0] <= 1'b0;
    end else if (pipe_en) begin
      td_vld_r[0] <= sq_vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      td_x_r[0]    <= sq_x_r[W];
      td_y_r[0]    <= sq_y_r[W];
      td_len_r[0]  <= td_len;
      td_mode_r[0] <= td_mode_nxt;
      td_span_r[0] <= td_span;
      td_rem_r[0]  <= td_num[2*W-1:W];
      td_lo_r[0]   <= td_num[W-1:0];
      td_q_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_tdiv
    logic [W:0] sh, diff;
    logic       ge;

    assign sh   = {td_rem_r[k], td_lo_r[k][W-1-k]};
    assign ge   = sh >= {1'b0, td_span_r[k]};
    assign diff = sh - {1'b0, td_span_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        td_vld_r[k+1] <= 1'b0;
      end else if (pipe_en) begin
        td_vld_r[k+1] <= td_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        td_x_r[k+1]    <= td_x_r[k];
        td_y_r[k+1]    <= td_y_r[k];
        td_len_r[k+1]  <= td_len_r[k];
        td_mode_r[k+1] <= td_mode_r[k];
        td_span_r[k+1] <= td_span_r[k];
        td_lo_r[k+1]   <= td_lo_r[k];
        td_rem_r[k+1]  <= ge ? diff[W-1:0] : sh[W-1:0];
        td_q_r[k+1]    <= {td_q_r[k][W-2:0], ge};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage M: select target length, multiply raw magnitudes by it
  // --------------------------------------------------------------------------
  logic                m_vld_r;
  logic signed [W-1:0] m_x_r, m_y_r;
  logic [W-1:0]        m_len_r, m_tgt_r;
  logic [2*W-1:0]      m_px_r, m_py_r;
  logic [W-1:0]        m_tgt_nxt, m_ax, m_ay;

  always_comb begin
    case (td_mode_r[W])
      jrdz_pkg::MODE_ZERO: m_tgt_nxt = '0;
      jrdz_pkg::MODE_FULL: m_tgt_nxt = FULL_U;
      jrdz_pkg::MODE_DIV:  m_tgt_nxt = td_q_r[W];
      default:             m_tgt_nxt = '0;
    endcase
  end

  assign m_ax = td_x_r[W][W-1] ? W'(-td_x_r[W]) : W'(td_x_r[W]);
  assign m_ay = td_y_r[W][W-1] ? W'(-td_y_r[W]) : W'(td_y_r[W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (pipe_en) begin
      m_vld_r <= td_vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m_x_r   <= td_x_r[W];
      m_y_r   <= td_y_r[W];
      m_len_r <= td_len_r[W];
      m_tgt_r <= m_tgt_nxt;
      m_px_r  <= m_ax * m_tgt_nxt;
      m_py_r  <= m_ay * m_tgt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Rescale: add half the length, then divide both axes by the length
  // --------------------------------------------------------------------------
  logic                rd_vld_r  [W+1];
  logic signed [W-1:0] rd_x_r    [W+1];
  logic signed [W-1:0] rd_y_r    [W+1];
  logic [W-1:0]        rd_len_r  [W+1];
  logic [W-1:0]        rd_tgt_r  [W+1];
  logic [W-1:0]        rd_lox_r  [W+1];
  logic [W-1:0]        rd_loy_r  [W+1];
  logic [W-1:0]        rd_remx_r [W+1];
  logic [W-1:0]        rd_remy_r [W+1];
  logic [W-1:0]        rd_qx_r   [W+1];
  logic [W-1:0]        rd_qy_r   [W+1];

  logic [2*W-1:0] rd_numx, rd_numy;

  assign rd_numx = m_px_r + {{(W+1){1'b0}}, m_len_r[W-1:1]};
  assign rd_numy = m_py_r + {{(W+1){1'b0}}, m_len_r[W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r[0] <= 1'b0;
    end else if (pipe_en) begin
      rd_vld_r[0] <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rd_x_r[0]    <= m_x_r;
      rd_y_r[0]    <= m_y_r;
      rd_len_r[0]  <= m_len_r;
      rd_tgt_r[0]  <= m_tgt_r;
      rd_remx_r[0] <= rd_numx[2*W-1:W];
      rd_remy_r[0] <= rd_numy[2*W-1:W];
      rd_lox_r[0]  <= rd_numx[W-1:0];
      rd_loy_r[0]  <= rd_numy[W-1:0];
      rd_qx_r[0]   <= '0;
      rd_qy_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_rdiv
    logic [W:0] shx, shy, dfx, dfy;
    logic       gex, gey;

    assign shx = {rd_remx_r[k], rd_lox_r[k][W-1-k]};
    assign shy = {rd_remy_r[k], rd_loy_r[k][W-1-k]};
    assign gex = shx >= {1'b0, rd_len_r[k]};
    assign gey = shy >= {1'b0, rd_len_r[k]};
    assign dfx = shx - {1'b0, rd_len_r[k]};
    assign dfy = shy - {1'b0, rd_len_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rd_vld_r[k+1] <= 1'b0;
      end else if (pipe_en) begin
        rd_vld_r[k+1] <= rd_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        rd_x_r[k+1]    <= rd_x_r[k];
        rd_y_r[k+1]    <= rd_y_r[k];
        rd_len_r[k+1]  <= rd_len_r[k];
        rd_tgt_r[k+1]  <= rd_tgt_r[k];
        rd_lox_r[k+1]  <= rd_lox_r[k];
        rd_loy_r[k+1]  <= rd_loy_r[k];
        rd_remx_r[k+1] <= gex ? dfx[W-1:0] : shx[W-1:0];
        rd_remy_r[k+1] <= gey ? dfy[W-1:0] : shy[W-1:0];
        rd_qx_r[k+1]   <= {rd_qx_r[k][W-2:0], gex};
        rd_qy_r[k+1]   <= {rd_qy_r[k][W-2:0], gey};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage S: restore sign and saturate the corrected vector
  // --------------------------------------------------------------------------
  function automatic logic signed [W-1:0] sat_q(input logic neg, input logic [W-1:0] q);
    logic signed [W-1:0] r;
    if (!neg) begin
      r = (q > MAX_POS) ? MAX_POS : q;
    end else begin
      r = (q > FULL_U) ? FULL_U : W'(-q);
    end
    return r;
  endfunction

  logic                s_vld_r;
  logic signed [W-1:0] s_x_r, s_y_r, s_cx_r, s_cy_r;
  logic [W-1:0]        s_tgt_r;
  logic                s_len_zero;

  assign s_len_zero = (rd_len_r[W] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s_vld_r <= rd_vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s_x_r   <= rd_x_r[W];
      s_y_r   <= rd_y_r[W];
      s_tgt_r <= rd_tgt_r[W];
      s_cx_r  <= s_len_zero ? '0 : sat_q(rd_x_r[W][W-1], rd_qx_r[W]);
      s_cy_r  <= s_len_zero ? '0 : sat_q(rd_y_r[W][W-1], rd_qy_r[W]);
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC vectoring: fold into the right half plane, then one step per stage
  // --------------------------------------------------------------------------
  logic                 co_vld_r  [N+1];
  logic signed [CW-1:0] co_x_r    [N+1];
  logic signed [CW-1:0] co_y_r    [N+1];
  logic signed [ZW-1:0] co_z_r    [N+1];
  logic                 co_zero_r [N+1];
  logic signed [W-1:0]  co_cx_r   [N+1];
  logic signed [W-1:0]  co_cy_r   [N+1];
  logic [W-1:0]         co_tgt_r  [N+1];
  logic signed [W-1:0]  co_rx_r   [N+1];
  logic signed [W-1:0]  co_ry_r   [N+1];

  logic signed [CW-1:0] co_xe, co_ye, co_x_nxt, co_y_nxt;
  logic signed [ZW-1:0] co_z_nxt;

  assign co_xe = {{(CW-W){s_cx_r[W-1]}}, s_cx_r} << 8;
  assign co_ye = {{(CW-W){s_cy_r[W-1]}}, s_cy_r} << 8;

  always_comb begin
    co_x_nxt = co_xe;
    co_y_nxt = co_ye;
    co_z_nxt = '0;
    if (co_xe[CW-1]) begin
      co_x_nxt = -co_xe;
      co_y_nxt = -co_ye;
      co_z_nxt = co_ye[CW-1] ? -jrdz_pkg::HALF_TURN : jrdz_pkg::HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      co_vld_r[0] <= 1'b0;
    end else if (pipe_en) begin
      co_vld_r[0] <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      co_x_r[0]    <= co_x_nxt;
      co_y_r[0]    <= co_y_nxt;
      co_z_r[0]    <= co_z_nxt;
      co_zero_r[0] <= (s_cx_r == '0) && (s_cy_r == '0);
      co_cx_r[0]   <= s_cx_r;
      co_cy_r[0]   <= s_cy_r;
      co_tgt_r[0]  <= s_tgt_r;
      co_rx_r[0]   <= s_x_r;
      co_ry_r[0]   <= s_y_r;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_cordic
    logic signed [CW-1:0] xs, ys, xn, yn;
    logic signed [ZW-1:0] at, zn;

    assign xs = co_x_r[s] >>> s;
    assign ys = co_y_r[s] >>> s;
    assign at = jrdz_pkg::atan_deg16(5'(s));

    // rotate toward the x axis; hold once y reaches zero
    always_comb begin
      xn = co_x_r[s];
      yn = co_y_r[s];
      zn = co_z_r[s];
      if (co_y_r[s][CW-1]) begin
        xn = co_x_r[s] - ys;
        yn = co_y_r[s] + xs;
        zn = co_z_r[s] - at;
      end else if (co_y_r[s] != '0) begin
        xn = co_x_r[s] + ys;
        yn = co_y_r[s] - xs;
        zn = co_z_r[s] + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        co_vld_r[s+1] <= 1'b0;
      end else if (pipe_en) begin
        co_vld_r[s+1] <= co_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        co_x_r[s+1]    <= xn;
        co_y_r[s+1]    <= yn;
        co_z_r[s+1]    <= zn;
        co_zero_r[s+1] <= co_zero_r[s];
        co_cx_r[s+1]   <= co_cx_r[s];
        co_cy_r[s+1]   <= co_cy_r[s];
        co_tgt_r[s+1]  <= co_tgt_r[s];
        co_rx_r[s+1]   <= co_rx_r[s];
        co_ry_r[s+1]   <= co_ry_r[s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: round the angle to degrees * 64 and clamp
  // --------------------------------------------------------------------------
  logic signed [ZW-1:0] o_rnd, o_clamp;
  logic signed [AW-1:0] o_ang_nxt;

  assign o_rnd = (co_z_r[N] + jrdz_pkg::ANG_ROUND) >>> jrdz_pkg::ANG_SHIFT;

  always_comb begin
    o_clamp = o_rnd;
    if (o_rnd > jrdz_pkg::ANG_LIMIT) begin
      o_clamp = jrdz_pkg::ANG_LIMIT;
    end else if (o_rnd < -jrdz_pkg::ANG_LIMIT) begin
      o_clamp = -jrdz_pkg::ANG_LIMIT;
    end
    o_ang_nxt = co_zero_r[N] ? '0 : o_clamp[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= co_vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_corrected_x_r     <= co_cx_r[N];
      out_corrected_y_r     <= co_cy_r[N];
      out_magnitude_r       <= co_tgt_r[N];
      out_orientation_deg_r <= o_ang_nxt;
      out_raw_echo_x_r      <= co_rx_r[N];
      out_raw_echo_y_r      <= co_ry_r[N];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_corrected_x     = out_corrected_x_r;
  assign out_corrected_y     = out_corrected_y_r;
  assign out_magnitude       = out_magnitude_r;
  assign out_orientation_deg = out_orientation_deg_r;
  assign out_raw_echo_x      = out_raw_echo_x_r;
  assign out_raw_echo_y      = out_raw_echo_y_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `JRDZ_ASSERT_IMP(a_mag_zero_vec, clk, rst_n, out_valid_r && (out_magnitude_r == '0), (out_corrected_x_r == '0) && (out_corrected_y_r == '0))
  `JRDZ_ASSERT_IMP(a_zero_vec_ang, clk, rst_n, out_valid_r && (out_corrected_x_r == '0) && (out_corrected_y_r == '0), out_orientation_deg_r == '0)
  `JRDZ_ASSERT_IMP(a_mag_range, clk, rst_n, out_valid_r, out_magnitude_r <= FULL_U)
  `JRDZ_ASSERT_NXT(a_pipe_hold, clk, rst_n, !pipe_en, $stable(co_z_r[N]) && $stable(out_orientation_deg_r))

endmodule
